### rtl/core/wsf_pkg.sv
// Shared types, constants and helper functions for the weighted 3x3 smoothing filter.
// Used by the filter top, kernel, result queue and checker; depends on nothing else.
package wsf_pkg;

   // Geometry
   localparam int unsigned MaxWidth  = 2048;
   localparam int unsigned HeightMax = 2048;
   localparam int unsigned MinSize   = 3;
   localparam int unsigned ColW      = $clog2(MaxWidth);
   localparam int unsigned RowW      = $clog2(HeightMax);

   // Configuration port
   localparam int unsigned CsrW    = 12;
   localparam int unsigned CsrIdxW = 1;
   localparam logic [CsrW-1:0] WidthReset  = 12'd640;
   localparam logic [CsrW-1:0] HeightReset = 12'd480;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Pixel format: channel 0 red, 1 green, 2 blue, each unsigned Q8.8
   localparam int unsigned NumChan = 3;
   localparam int unsigned ChanW   = 16;

   typedef logic [NumChan-1:0][ChanW-1:0] pixel_type;

   // Line memory entry: row above and row two above at one column
   typedef struct packed {
      pixel_type above;
      pixel_type above2;
   } line_type;

   localparam int unsigned LineW = $bits(line_type);

   // One window column, top to bottom
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // The eight neighbors of the window center
   typedef struct packed {
      pixel_type ul;
      pixel_type up;
      pixel_type ur;
      pixel_type lf;
      pixel_type rt;
      pixel_type dl;
      pixel_type dn;
      pixel_type dr;
   } taps_type;

   // Weights: orthogonal 1.0 (shift by 15), diagonal 1/sqrt2 in Q0.15,
   // normalization 1/(4+4/sqrt2) in Q0.15, total shift back to Q8.8
   localparam int unsigned OrthoShift = 15;
   localparam int unsigned DiagWW     = 15;
   localparam int unsigned NormWW     = 13;
   localparam logic [DiagWW-1:0] DiagWeight = 15'd23170;
   localparam logic [NormWW-1:0] NormWeight = 13'd4799;
   localparam int unsigned NormShift  = 30;

   localparam int unsigned OrthoW = ChanW + 2;
   localparam int unsigned DiagPW = OrthoW + DiagWW;
   localparam int unsigned SumW   = DiagPW + 1;
   localparam int unsigned ProdW  = SumW + NormWW;
   localparam int unsigned ResW   = ProdW - NormShift;

   // Per-item control carried down the pipeline
   typedef struct packed {
      logic valid;
      logic emit;
      logic interior;
      logic tail;
      logic last_row;
   } item_ctl_type;

   localparam int unsigned PipeDepth = 4;

   // Result queue entry; tail adds the zero row-end result after the pixel
   typedef struct packed {
      pixel_type rgb;
      logic      tail;
      logic      last_row;
   } rsp_entry_type;

   localparam int unsigned RspDepth = 8;
   localparam int unsigned RspPtrW  = $clog2(RspDepth);
   localparam int unsigned RspCntW  = $clog2(RspDepth + 1);

   // Clamp a written width to [MinSize, MaxWidth] and return the last column
   function automatic logic [ColW-1:0] width_last(input logic [CsrW-1:0] v);
      int unsigned w;
      w = 32'(v);
      if (w < MinSize) w = MinSize;
      if (w > MaxWidth) w = MaxWidth;
      return ColW'(w - 1);
   endfunction

   // Clamp a written height to [MinSize, HeightMax] and return the last row
   function automatic logic [RowW-1:0] height_last(input logic [CsrW-1:0] v);
      int unsigned h;
      h = 32'(v);
      if (h < MinSize) h = MinSize;
      if (h > HeightMax) h = HeightMax;
      return RowW'(h - 1);
   endfunction

endpackage

### rtl/core/weighted_3x3_smoothing_filter_top.sv
// Top level of the weighted 3x3 smoothing filter: counters, line memory access,
// window registers and result credit. Uses wsf_pkg, wsf_line_ram, wsf_kernel, wsf_rsp_queue.
//
//   port group | direction | handshake           | payload
//   req_*      | in        | req_valid/req_ready | red, green, blue (Q8.8)
//   rsp_*      | out       | rsp_valid/rsp_ready | red, green, blue, row_end, frame_end
//   csr_*      | in        | csr_we              | csr_index, csr_wdata (12 bits)
//
// One pixel per clock while req_ready is high. A result passes the line memory read
// register, the three kernel stages and the result queue before it is presented.
// Reset is synchronous; the line memory is not cleared and needs no clearing pass.
// req_ready drops only in reset or while eight emitting pixels are in the pipeline or queued.
// A register write restarts the image at row 0, column 0.
module weighted_3x3_smoothing_filter_top import wsf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_red_in,
   input  logic [15:0]         req_green_in,
   input  logic [15:0]         req_blue_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_red_out,
   output logic [15:0]         rsp_green_out,
   output logic [15:0]         rsp_blue_out,
   output logic                rsp_row_end,
   output logic                rsp_frame_end,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrW-1:0]     csr_wdata
);

   logic [ColW-1:0]    wlast_ff, wlast_in;
   logic [RowW-1:0]    hlast_ff, hlast_in;
   logic [ColW-1:0]    col_ff, col_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [RspCntW-1:0] pend_ff, pend_in;
   item_ctl_type       ctl_ff [PipeDepth];
   item_ctl_type       ctl_new;
   pixel_type          pix_ff;
   logic [ColW-1:0]    col_s1_ff;
   column_type         left_ff;
   column_type         mid_ff;
   line_type           line_rd;
   line_type           line_wr;
   logic [LineW-1:0]   line_rd_bits;
   taps_type           taps;
   pixel_type          kernel_out;
   rsp_entry_type      push_entry;
   logic               push;
   logic               pop;
   logic               req_transfer;

   assign req_ready    = !reset && (pend_ff < RspCntW'(RspDepth));
   assign req_transfer = req_valid && req_ready;

   // classify the incoming pixel by its position
   always_comb begin
      ctl_new.valid    = req_transfer;
      ctl_new.emit     = (row_ff != '0) && (col_ff != '0);
      ctl_new.interior = (row_ff > RowW'(1)) && (col_ff > ColW'(1));
      ctl_new.tail     = (col_ff == wlast_ff);
      ctl_new.last_row = (row_ff == hlast_ff);
   end

   // size registers and raster position; a register write restarts the image
   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  wlast_in = width_last(csr_wdata);
            CSR_IMAGE_HEIGHT: hlast_in = height_last(csr_wdata);
            default:          wlast_in = wlast_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (req_transfer) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + RowW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   // hold one credit per emitting pixel until its queue entry retires
   assign pend_in = pend_ff + RspCntW'(req_transfer && ctl_new.emit) - RspCntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= width_last(WidthReset);
         hlast_ff <= height_last(HeightReset);
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
      end
   end

   // advance item control down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PipeDepth; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_new;
         for (int i = 1; i < PipeDepth; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // hold pixel and column for the write-back cycle
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         pix_ff    <= {req_blue_in, req_green_in, req_red_in};
         col_s1_ff <= col_ff;
      end
   end

   // Line memory: read at transfer, write back in the cycle after. The same column
   // comes back only after a full row of at least three pixels, so no forwarding.
   assign line_rd         = line_type'(line_rd_bits);
   assign line_wr.above   = pix_ff;
   assign line_wr.above2  = line_rd.above;

   wsf_line_ram #(
      .DataW (LineW),
      .Depth (MaxWidth)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ctl_ff[0].valid),
      .wr_addr (col_s1_ff),
      .wr_data (line_wr),
      .rd_en   (req_transfer),
      .rd_addr (col_ff),
      .rd_data (line_rd_bits)
   );

   // shift window: center column moves left, new column enters
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         mid_ff  <= '0;
      end else if (ctl_ff[0].valid) begin
         left_ff    <= mid_ff;
         mid_ff.top <= line_rd.above2;
         mid_ff.mid <= line_rd.above;
         mid_ff.bot <= pix_ff;
      end
   end

   // gather the eight neighbors
   always_comb begin
      taps.ul = left_ff.top;
      taps.lf = left_ff.mid;
      taps.dl = left_ff.bot;
      taps.up = mid_ff.top;
      taps.dn = mid_ff.bot;
      taps.ur = line_rd.above2;
      taps.rt = line_rd.above;
      taps.dr = pix_ff;
   end

   wsf_kernel u_kernel (
      .clock  (clock),
      .taps   (taps),
      .result (kernel_out)
   );

   // zero the border, queue one entry per emitting pixel
   assign push                = ctl_ff[PipeDepth-1].valid && ctl_ff[PipeDepth-1].emit;
   assign push_entry.rgb      = ctl_ff[PipeDepth-1].interior ? kernel_out : '0;
   assign push_entry.tail     = ctl_ff[PipeDepth-1].tail;
   assign push_entry.last_row = ctl_ff[PipeDepth-1].last_row;

   wsf_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .push_entry    (push_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### rtl/core/wsf_line_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// Standalone; holds the two previous image rows for the filter.
module wsf_line_ram #(
   parameter int unsigned DataW = 96,
   parameter int unsigned Depth = 2048,
   localparam int unsigned AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/wsf_kernel.sv
// Weighted 3x3 neighbor sum and normalization, three register stages per channel.
// Depends on wsf_pkg for the tap layout and fixed-point weights.
module wsf_kernel import wsf_pkg::*; (
   input  logic      clock,
   input  taps_type  taps,
   output pixel_type result
);

   logic [OrthoW-1:0] ortho_ff [NumChan];
   logic [OrthoW-1:0] ortho_in [NumChan];
   logic [OrthoW-1:0] diag_ff  [NumChan];
   logic [OrthoW-1:0] diag_in  [NumChan];
   logic [SumW-1:0]   sum_ff   [NumChan];
   logic [SumW-1:0]   sum_in   [NumChan];
   logic [ProdW-1:0]  prod_ff  [NumChan];
   logic [ProdW-1:0]  prod_in  [NumChan];

   // stage 1: add orthogonal and diagonal neighbors
   always_comb begin
      for (int ch = 0; ch < NumChan; ch++) begin
         ortho_in[ch] = OrthoW'(taps.up[ch]) + OrthoW'(taps.dn[ch])
                      + OrthoW'(taps.lf[ch]) + OrthoW'(taps.rt[ch]);
         diag_in[ch]  = OrthoW'(taps.ul[ch]) + OrthoW'(taps.ur[ch])
                      + OrthoW'(taps.dl[ch]) + OrthoW'(taps.dr[ch]);
      end
   end

   // stage 2: apply weights, orthogonal weight is a plain shift
   always_comb begin
      for (int ch = 0; ch < NumChan; ch++) begin
         sum_in[ch] = SumW'({ortho_ff[ch], OrthoShift'(0)})
                    + SumW'(DiagPW'(diag_ff[ch]) * DiagPW'(DiagWeight));
      end
   end

   // stage 3: normalize
   always_comb begin
      for (int ch = 0; ch < NumChan; ch++) begin
         prod_in[ch] = ProdW'(sum_ff[ch]) * ProdW'(NormWeight);
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NumChan; ch++) begin
         ortho_ff[ch] <= ortho_in[ch];
         diag_ff[ch]  <= diag_in[ch];
         sum_ff[ch]   <= sum_in[ch];
         prod_ff[ch]  <= prod_in[ch];
      end
   end

   // truncate back to Q8.8 and saturate
   always_comb begin
      for (int ch = 0; ch < NumChan; ch++) begin
         if (prod_ff[ch][ProdW-1 -: (ResW - ChanW)] != '0) begin
            result[ch] = '1;
         end else begin
            result[ch] = prod_ff[ch][NormShift +: ChanW];
         end
      end
   end

endmodule

### rtl/core/wsf_rsp_queue.sv
// Result queue and output formatter: stores one entry per emitting pixel and
// expands a row-end entry into the pixel result plus a zero row-end result. Uses wsf_pkg.
module wsf_rsp_queue import wsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_entry_type push_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_red_out,
   output logic [15:0]   rsp_green_out,
   output logic [15:0]   rsp_blue_out,
   output logic          rsp_row_end,
   output logic          rsp_frame_end
);

   rsp_entry_type        entry_ff [RspDepth];
   logic [RspPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RspPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RspCntW-1:0]   count_ff, count_in;
   logic                 tail_phase_ff, tail_phase_in;
   rsp_entry_type        head;
   logic                 transfer;

   assign head      = entry_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign transfer  = rsp_valid && rsp_ready;
   // retire the entry after its last result leaves
   assign pop       = transfer && (tail_phase_ff || !head.tail);

   // format the result at the head
   always_comb begin
      if (tail_phase_ff) begin
         rsp_red_out   = '0;
         rsp_green_out = '0;
         rsp_blue_out  = '0;
         rsp_row_end   = 1'b1;
         rsp_frame_end = head.last_row;
      end else begin
         rsp_red_out   = head.rgb[0];
         rsp_green_out = head.rgb[1];
         rsp_blue_out  = head.rgb[2];
         rsp_row_end   = 1'b0;
         rsp_frame_end = 1'b0;
      end
   end

   // advance pointers, count and tail phase
   always_comb begin
      wr_ptr_in     = push ? wr_ptr_ff + RspPtrW'(1) : wr_ptr_ff;
      rd_ptr_in     = pop  ? rd_ptr_ff + RspPtrW'(1) : rd_ptr_ff;
      count_in      = count_ff + RspCntW'(push) - RspCntW'(pop);
      tail_phase_in = tail_phase_ff;
      if (transfer && head.tail) begin
         tail_phase_in = !tail_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         tail_phase_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         tail_phase_ff <= tail_phase_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/wsf_checker.sv
// Port-level checks for the weighted 3x3 smoothing filter, bound to the top level.
// Uses wsf_pkg for port widths.
module wsf_checker import wsf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [15:0]        req_red_in,
   input logic [15:0]        req_green_in,
   input logic [15:0]        req_blue_in,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_red_out,
   input logic [15:0]        rsp_green_out,
   input logic [15:0]        rsp_blue_out,
   input logic               rsp_row_end,
   input logic               rsp_frame_end,
   input logic               csr_we,
   input logic [CsrIdxW-1:0] csr_index,
   input logic [CsrW-1:0]    csr_wdata
);

   // nothing is presented right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented after reset");

   // frame end only on a row-end result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame_end without row_end");

   // the row-end result is a border pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |->
         (rsp_red_out == '0) && (rsp_green_out == '0) && (rsp_blue_out == '0))
      else $error("row-end result not zero");

   // a row-end result is followed by a pixel result, never by another row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_row_end |=> !(rsp_valid && rsp_row_end))
      else $error("two row-end results back to back");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out) &&
         $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_row_end) &&
         $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind weighted_3x3_smoothing_filter_top wsf_checker u_wsf_checker (.*);

### test/wsf_result_check.sv
// Result checker for the weighted 3x3 smoothing filter: tracks geometry writes, predicts
// every filtered pixel from the request transfers and compares each response transfer.
// Depends on wsf_pkg for the pixel, window column and register index types.
module wsf_result_check import wsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  logic [15:0]     req_red_in,
   input  logic [15:0]     req_green_in,
   input  logic [15:0]     req_blue_in,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic [15:0]     rsp_red_out,
   input  logic [15:0]     rsp_green_out,
   input  logic [15:0]     rsp_blue_out,
   input  logic            rsp_row_end,
   input  logic            rsp_frame_end,
   input  logic            csr_we,
   input  csr_index_type   csr_index,
   input  logic [CsrW-1:0] csr_wdata,
   output int              fail_count,
   output int              pending
);

   // Q1.15 weights and the Q0.15 normalization gain
   localparam longint unsigned OrthoGain = 32768;
   localparam longint unsigned DiagGain  = 23170;
   localparam longint unsigned NormGain  = 4799;
   localparam int unsigned     NormBits  = 30;

   typedef struct packed {
      pixel_type rgb;
      logic      row_end;
      logic      frame_end;
   } filtered_type;

   filtered_type    filtered_q[$];
   pixel_type       prior_row [MaxWidth];   // row above the current one
   pixel_type       older_row [MaxWidth];   // row two above
   column_type      win_left;               // column c-2
   column_type      win_mid;                // column c-1, the window center
   logic [CsrW-1:0] width_reg;
   logic [CsrW-1:0] height_reg;
   int unsigned     col;
   int unsigned     row;
   int              errors = 0;
   int              waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   function automatic int unsigned clamp_size(logic [CsrW-1:0] v, int unsigned hi);
      int unsigned s;
      s = 32'(v);
      if (s < MinSize) s = MinSize;
      if (s > hi) s = hi;
      return s;
   endfunction

   // Weighted mean of the eight neighbors, center left out, saturated to 16 bits
   function automatic pixel_type neighbor_mean(column_type lt, column_type md,
                                               column_type rt);
      pixel_type       mean;
      longint unsigned ortho;
      longint unsigned diag;
      longint unsigned scaled;
      for (int ch = 0; ch < NumChan; ch++) begin
         ortho  = 64'(md.top[ch]) + 64'(md.bot[ch]) + 64'(lt.mid[ch]) + 64'(rt.mid[ch]);
         diag   = 64'(lt.top[ch]) + 64'(lt.bot[ch]) + 64'(rt.top[ch]) + 64'(rt.bot[ch]);
         scaled = ((ortho * OrthoGain + diag * DiagGain) * NormGain) >> NormBits;
         mean[ch] = (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
      end
      return mean;
   endfunction

   // Advance the image position by one pixel and queue the results it releases
   function automatic void smooth_pixel(pixel_type px);
      int unsigned  w;
      int unsigned  h;
      column_type   right;
      pixel_type    mean;
      filtered_type res;
      w = clamp_size(width_reg, MaxWidth);
      h = clamp_size(height_reg, HeightMax);
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      right.top = older_row[col];
      right.mid = prior_row[col];
      right.bot = px;
      mean = neighbor_mean(win_left, win_mid, right);

      // output (row-1, col-1); border outputs are zero, the last column adds a zero tail
      if (row >= 1 && col >= 1) begin
         res.rgb       = (row >= 2 && col >= 2) ? mean : '0;
         res.row_end   = 1'b0;
         res.frame_end = 1'b0;
         filtered_q.push_back(res);
         if (col == w - 1) begin
            res.rgb       = '0;
            res.row_end   = 1'b1;
            res.frame_end = (row == h - 1);
            filtered_q.push_back(res);
         end
      end

      // shift the window and roll the line stores
      win_left       = win_mid;
      win_mid        = right;
      older_row[col] = prior_row[col];
      prior_row[col] = px;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
   endfunction

   always @(posedge clock) begin : watch
      filtered_type want;
      if (reset === 1'b1) begin
         filtered_q.delete();
         width_reg  = WidthReset;
         height_reg = HeightReset;
         col        = 0;
         row        = 0;
         win_left   = '0;
         win_mid    = '0;
         for (int i = 0; i < MaxWidth; i++) begin
            prior_row[i] = '0;
            older_row[i] = '0;
         end
      end else begin
         // a register write restarts the image
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
            col = 0;
            row = 0;
         end

         if (req_valid === 1'b1 && req_ready === 1'b1)
            smooth_pixel({req_blue_in, req_green_in, req_red_in});

         // compare each response transfer with the oldest prediction
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (filtered_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display({"%0t: response with nothing predicted: ",
                            "rgb %h %h %h row_end %b frame_end %b"},
                           $realtime, rsp_red_out, rsp_green_out, rsp_blue_out,
                           rsp_row_end, rsp_frame_end);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_red_out !== want.rgb[0] || rsp_green_out !== want.rgb[1] ||
                   rsp_blue_out !== want.rgb[2] || rsp_row_end !== want.row_end ||
                   rsp_frame_end !== want.frame_end) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: mismatch: expected rgb %h %h %h row_end %b ",
                               "frame_end %b, got rgb %h %h %h row_end %b frame_end %b"},
                              $realtime, want.rgb[0], want.rgb[1], want.rgb[2],
                              want.row_end, want.frame_end, rsp_red_out, rsp_green_out,
                              rsp_blue_out, rsp_row_end, rsp_frame_end);
               end
            end
         end
      end
      waiting = filtered_q.size();
   end

endmodule

### test/testbench.sv
// Top of the smoothing filter testbench: clock, reset, pixel and geometry stimulus,
// response back-pressure and the verdict. Depends on wsf_pkg, the filter top and
// wsf_result_check, which predicts and compares every result.
module testbench;
   import wsf_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [15:0]     req_red_in;
   logic [15:0]     req_green_in;
   logic [15:0]     req_blue_in;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [15:0]     rsp_red_out;
   logic [15:0]     rsp_green_out;
   logic [15:0]     rsp_blue_out;
   logic            rsp_row_end;
   logic            rsp_frame_end;
   logic            csr_we;
   csr_index_type   csr_index;
   logic [CsrW-1:0] csr_wdata;
   int              fail_count;
   int              pending;

   bit              src_idle_en;
   bit              sink_idle_en;
   bit              sink_hold;
   int unsigned     frame_w;
   int unsigned     frame_h;

   weighted_3x3_smoothing_filter_top dut (.*);

   wsf_result_check result_check (.*);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin : watchdog
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: random stall bursts, plus one long hold on request
   initial begin : sink
      rsp_ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (sink_hold) begin
            sink_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (80) @(negedge clock);
         end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic pixel_type random_pixel(bit bright);
      pixel_type px;
      for (int ch = 0; ch < NumChan; ch++) begin
         if (bright) px[ch] = 16'($urandom_range(16'hFFFF, 16'hFF00));
         else if ($urandom_range(0, 7) == 0) px[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
         else px[ch] = 16'($urandom);
      end
      return px;
   endfunction

   // Offer one pixel, with an optional gap first; hold valid until the transfer
   task automatic send_pixel(input pixel_type px);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= px[0];
      req_green_in <= px[1];
      req_blue_in  <= px[2];
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has left the block
   task automatic drain_filter();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write the geometry registers while the block is idle
   task automatic program_size(input bit do_w, input logic [CsrW-1:0] w,
                               input bit do_h, input logic [CsrW-1:0] h);
      drain_filter();
      if (do_w) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_wdata <= w;
         frame_w = (32'(w) < MinSize) ? MinSize : ((32'(w) > MaxWidth) ? MaxWidth : 32'(w));
         @(negedge clock);
      end
      if (do_h) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_wdata <= h;
         frame_h = (32'(h) < MinSize) ? MinSize : ((32'(h) > HeightMax) ? HeightMax : 32'(h));
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned items, input bit bright, input bit pause_mid);
      for (int unsigned n = 0; n < items; n++) begin
         if (pause_mid && n == items / 2) drain_filter();
         send_pixel(random_pixel(bright));
      end
   endtask

   initial begin : stimulus
      pixel_type       px;
      int unsigned     random_items;
      int unsigned     area;
      int unsigned     items;
      bit              first;
      bit              do_w;
      bit              do_h;
      logic [CsrW-1:0] raw_w;
      logic [CsrW-1:0] raw_h;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_red_in   <= '0;
      req_green_in <= '0;
      req_blue_in  <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_wdata    <= '0;
      frame_w      = 640;
      frame_h      = 480;
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // smallest frame: saturating all-ones frame, a mixed frame, then a partial one
      program_size(1'b1, 12'd3, 1'b1, 12'd3);
      repeat (9) send_pixel('1);
      for (int i = 0; i < 9; i++) begin
         px[0] = i[0] ? 16'hFFFF : 16'h0000;
         px[1] = 16'h0101 << i;
         px[2] = i[0] ? 16'h7FFF : 16'h8000;
         send_pixel(px);
      end
      repeat (7) send_pixel('0);

      // clamped sizes at both ends; a short stretch of the widest row
      program_size(1'b1, 12'd0, 1'b1, 12'd1);
      run_phase(12, 1'b0, 1'b0);
      program_size(1'b1, 12'd4095, 1'b1, 12'd3);
      run_phase(40, 1'b0, 1'b0);
      program_size(1'b1, 12'd3, 1'b1, 12'd4095);
      run_phase(60, 1'b0, 1'b1);
      program_size(1'b0, 12'd0, 1'b1, 12'd2048);
      run_phase(30, 1'b1, 1'b0);

      // random geometry and frames, often cut short by the next write
      random_items = 0;
      first = 1'b1;
      while (random_items < 220) begin
         do_w  = 1'($urandom_range(0, 1));
         do_h  = !do_w || ($urandom_range(0, 1) == 1);
         raw_w = CsrW'($urandom_range(0, 12));
         raw_h = CsrW'($urandom_range(0, 7));
         if (first) begin
            do_w  = 1'b1;
            do_h  = 1'b1;
            raw_w = 12'd8;
            raw_h = 12'd6;
         end
         program_size(do_w, raw_w, do_h, raw_h);
         src_idle_en  = !first && ($urandom_range(0, 3) != 0);
         sink_idle_en = ($urandom_range(0, 3) != 0);
         area  = frame_w * frame_h;
         items = $urandom_range(0, 2) * area;
         if ($urandom_range(0, 1) == 1) items += $urandom_range(1, area - 1);
         if (items == 0) items = area;
         // fill the block against a long response hold
         if (first) begin
            items = 2 * area;
            sink_hold = 1'b1;
         end
         run_phase(items, $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
         random_items += items;
         first = 1'b0;
      end

      // closing stretch at full rate on both sides
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      program_size(1'b1, 12'd5, 1'b1, 12'd4);
      run_phase(40, 1'b0, 1'b0);
      drain_filter();
      repeat (8) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
